/* rtl/utf16_bytes_to_code_points_core_macros.svh */
// ----------------------------------------------------------------------------
// UTF-16 decoder assertion macros
// Shared concurrent assertion forms used by the decoder's RTL.
// ----------------------------------------------------------------------------
`ifndef UTF16_BYTES_TO_CODE_POINTS_CORE_MACROS_SVH
`define UTF16_BYTES_TO_CODE_POINTS_CORE_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define U16D_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u16dec: implication check failed");

// The expression must never be true outside reset.
`define U16D_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("u16dec: forbidden condition seen");

`endif

/* rtl/u16dec_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-16 decoder package
// Types and constants shared by the front, queue, back and top modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u16dec_pkg;

  localparam int CP_W   = 21;
  localparam int UNIT_W = 16;
  localparam int ADDR_W = 3;

  // Register indexes as taken from paddr[2].
  localparam logic REG_DEFAULT_BIG_ENDIAN = 1'b0;

  localparam logic [UNIT_W-1:0] MARK_NATIVE   = 16'hFEFF;
  localparam logic [UNIT_W-1:0] MARK_SWAPPED  = 16'hFFFE;
  localparam logic [UNIT_W-1:0] SURR_LO_START = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_HI_END   = 16'hDC00;
  localparam logic [UNIT_W-1:0] SURR_END      = 16'hE000;
  localparam logic [CP_W-1:0]   PLANE_BASE    = 21'h10000;
  localparam logic [CP_W-1:0]   CP_MAX        = 21'h10FFFF;

  // A decoded word handed from the front to the queue.
  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] cp;
  } cp_push_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/u16dec_front.sv */
// ----------------------------------------------------------------------------
// UTF-16 decoder front end
// Pairs bytes into code units, handles the byte order mark and surrogates.
// ----------------------------------------------------------------------------
`default_nettype none

module u16dec_front
  import u16dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_in_text,
  input  logic       default_big_endian,
  input  q_status_t  q_status,
  output cp_push_t   push
);

  logic              byte_phase;
  logic [7:0]        held_byte;
  logic              at_first_unit;
  logic              order_is_big;
  logic              high_pending;
  logic [9:0]        high_bits;

  logic              accept;
  logic              order_eff;
  logic [UNIT_W-1:0] unit;
  logic              is_swapped_mark;
  logic              skip;
  logic              unit_low_surr;
  logic              unit_high_surr;
  logic              unit_plain;
  logic              emit;
  logic [CP_W-1:0]   cp_value;

  // Accept a byte whenever the queue has room for a word.
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Form the unit in the order in force; the first unit uses the register.
  assign order_eff       = at_first_unit ? default_big_endian : order_is_big;
  assign unit            = order_eff ? {held_byte, data_byte} : {data_byte, held_byte};
  assign is_swapped_mark = (unit == MARK_SWAPPED);
  assign skip            = at_first_unit && (is_swapped_mark || unit == MARK_NATIVE);

  // Classify the unit.
  assign unit_low_surr  = (unit >= SURR_HI_END) && (unit < SURR_END);
  assign unit_high_surr = (unit >= SURR_LO_START) && (unit < SURR_HI_END);
  assign unit_plain     = !unit_low_surr && !unit_high_surr;

  // A word comes out for a completed pair or for a plain unit.
  always_comb begin
    emit     = 1'b0;
    cp_value = {{(CP_W-UNIT_W){1'b0}}, unit};
    if (byte_phase && !skip) begin
      if (high_pending) begin
        emit     = unit_low_surr;
        cp_value = {1'b0, high_bits, unit[9:0]} + PLANE_BASE;
      end else begin
        emit = unit_plain;
      end
    end
  end

  assign push.valid = accept && emit;
  assign push.cp    = cp_value;

  // Decoder state update on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= 1'b0;
      at_first_unit <= 1'b1;
      order_is_big  <= 1'b0;
      high_pending  <= 1'b0;
    end else if (accept) begin
      // The end of a text restarts pairing and the mark check.
      if (last_in_text) begin
        byte_phase    <= 1'b0;
        at_first_unit <= 1'b1;
        high_pending  <= 1'b0;
      end else if (!byte_phase) begin
        byte_phase <= 1'b1;
      end else begin
        byte_phase    <= 1'b0;
        at_first_unit <= 1'b0;
        if (!skip && high_pending) begin
          high_pending <= 1'b0;
        end else if (!skip && unit_high_surr) begin
          high_pending <= 1'b1;
        end
      end
      // The first unit of a text fixes the byte order for the rest of it.
      if (byte_phase && at_first_unit) begin
        order_is_big <= default_big_endian ^ is_swapped_mark;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!byte_phase) begin
        held_byte <= data_byte;
      end else if (!skip && !high_pending && unit_high_surr) begin
        high_bits <= unit[9:0];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/u16dec_queue.sv */
// ----------------------------------------------------------------------------
// UTF-16 decoder queue
// Short first-in first-out buffer of decoded words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module u16dec_queue
  import u16dec_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic            clk,
  input  logic            rst,
  input  cp_push_t        push,
  input  logic            pop,
  output logic            q_valid,
  output logic [CP_W-1:0] q_data,
  output q_status_t       q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CP_W-1:0]  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);
  assign q_valid        = !q_status.empty;
  assign q_data         = mem[rd_ptr];

  assign do_push = push.valid && !q_status.full;
  assign do_pop  = pop && q_valid;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.cp;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/u16dec_back.sv */
// ----------------------------------------------------------------------------
// UTF-16 decoder back end
// Output register that presents one code point word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module u16dec_back
  import u16dec_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  logic [CP_W-1:0] q_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] code_point
);

  logic load;

  // Take the next word when the register is empty or being emptied.
  assign load = q_valid && (!out_valid || out_ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point <= q_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/utf16_bytes_to_code_points_core.sv */
// ----------------------------------------------------------------------------
// UTF-16 byte stream decoder
// Turns UTF-16 bytes, with byte order mark handling, into code points.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the in_valid/in_ready channel with data_byte and
//   last_in_text; last_in_text closes a text so the next byte starts a new
//   one. Decoded words leave on out_valid/out_ready as code_point.
//   The APB port holds default_big_endian at address 0; write it only while
//   the block is idle.
// Data path: the front decodes a word combinationally as the byte that
//   completes it is presented; the word then enters the queue and then the
//   output register.
// Throughput: one byte per cycle while in_ready is high; a word leaves
//   each cycle out_ready is high. When the receiver stalls, the output
//   register holds its word and the queue of QUEUE_DEPTH words keeps
//   filling; in_ready falls only once the queue is full.
// Reset (synchronous, rst high) empties queue and output, clears the byte
//   order register and sets the decoder to expect the start of a text.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf16_bytes_to_code_points_core_macros.svh"

module utf16_bytes_to_code_points_core
  import u16dec_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_in_text,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CP_W-1:0]   code_point
);

  logic              default_big_endian;
  cp_push_t          push;
  q_status_t         q_status;
  logic              q_valid;
  logic [CP_W-1:0]   q_data;
  logic              pop;
  logic              out_is_surr;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_big_endian <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == REG_DEFAULT_BIG_ENDIAN) begin
      default_big_endian <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_DEFAULT_BIG_ENDIAN) ? {31'b0, default_big_endian} : 32'b0;

  u16dec_front u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .data_byte          (data_byte),
    .last_in_text       (last_in_text),
    .default_big_endian (default_big_endian),
    .q_status           (q_status),
    .push               (push)
  );

  u16dec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_status (q_status)
  );

  u16dec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point)
  );

  // The word on the output lies in the surrogate range.
  assign out_is_surr = (code_point >= {5'b0, SURR_LO_START})
                       && (code_point < {5'b0, SURR_END});

  // A word shown is a Unicode scalar value.
  `U16D_ASSERT_IMPLY(a_cp_in_range, out_valid, code_point <= CP_MAX)
  `U16D_ASSERT_NEVER(a_cp_not_surrogate, out_valid && out_is_surr)
  // The queue only fills up behind a word held in the output register.
  `U16D_ASSERT_IMPLY(a_full_behind_output, q_status.full, out_valid)
  // Input is refused only when the queue has no room.
  `U16D_ASSERT_IMPLY(a_ready_unless_full, !q_status.full, in_ready)

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// UTF-16 byte stream decoder testbench
// Feeds UTF-16 texts one byte at a time through the valid/ready input and
// predicts each decoded code point in the testbench itself. The directed
// texts cover byte order marks, surrogate pairs, dropped units and odd
// endings. Random texts follow under both default byte orders, with random
// gaps and stalls on both channels and one stretch at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import u16dec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_PCT      = 36;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_LIMIT   = 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        data_byte = '0;
  logic              last_in_text = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CP_W-1:0]   code_point;

  // Shared control of the random gaps on both channels.
  bit gaps_on = 1'b1;
  int fail_count = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  // Decoder state as the testbench sees it.
  logic            order_reg = 1'b0;
  logic            half_unit = 1'b0;
  logic [7:0]      lead_byte = '0;
  logic            text_start = 1'b1;
  logic            text_big = 1'b0;
  logic            high_seen = 1'b0;
  logic [9:0]      high_ten = '0;

  logic [CP_W-1:0] pending_code_points[$];
  logic [7:0]      text_bytes[$];

  utf16_bytes_to_code_points_core uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_in_text (last_in_text),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_point   (code_point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the decoder state by one accepted byte and queue any code point.
  function automatic void decode_byte(input logic [7:0] b, input logic closes);
    logic [15:0]     unit;
    logic            skip;
    logic            was_first;
    logic [CP_W-1:0] supp;
    skip = 1'b0;
    if (!half_unit) begin
      lead_byte = b;
      half_unit = 1'b1;
    end else begin
      half_unit = 1'b0;
      was_first = text_start;
      if (text_start) begin
        text_start = 1'b0;
        text_big = order_reg;
      end
      unit = text_big ? {lead_byte, b} : {b, lead_byte};
      if (was_first) begin
        if (unit == MARK_SWAPPED) begin
          text_big = ~text_big;
          skip = 1'b1;
        end else if (unit == MARK_NATIVE) begin
          skip = 1'b1;
        end
      end
      if (!skip) begin
        if (high_seen) begin
          // Anything but a low surrogate swallows the pair.
          high_seen = 1'b0;
          if (unit >= SURR_HI_END && unit < SURR_END) begin
            supp = {1'b0, high_ten, unit[9:0]} + PLANE_BASE;
            pending_code_points.push_back(supp);
          end
        end else if (unit < SURR_LO_START || unit >= SURR_END) begin
          pending_code_points.push_back({5'd0, unit});
        end else if (unit < SURR_HI_END) begin
          high_seen = 1'b1;
          high_ten = unit[9:0];
        end
      end
    end
    if (closes) begin
      half_unit = 1'b0;
      text_start = 1'b1;
      high_seen = 1'b0;
    end
  endfunction

  // Send one byte, with a random gap before it, and wait for the handshake.
  task automatic send_byte(input logic [7:0] b, input logic closes);
    if (gaps_on) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_in_text <= closes;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, closes);
    bytes_sent++;
  endtask

  // Let every expected word arrive, plus the pipeline depth for bytes that
  // produce nothing.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Set the byte order used before a mark, once the block is idle.
  task automatic write_default_order(input logic big);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_DEFAULT_BIG_ENDIAN, 2'b00};
    pwdata <= {31'd0, big};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    order_reg = big;
  endtask

  // Append one code unit to the text in the given byte order.
  function automatic void append_unit(input logic [15:0] u, input logic big);
    if (big) begin
      text_bytes.push_back(u[15:8]);
      text_bytes.push_back(u[7:0]);
    end else begin
      text_bytes.push_back(u[7:0]);
      text_bytes.push_back(u[15:8]);
    end
  endfunction

  function automatic logic [15:0] random_bmp();
    if ($urandom_range(9) == 0)
      return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(1))
      return 16'($urandom_range(16'hD7FF));
    return 16'($urandom_range(16'hFFFF, 16'hE000));
  endfunction

  // Build one text: mostly well-formed units with an optional mark, some
  // broken surrogates and odd endings, and now and then plain noise.
  task automatic send_random_text();
    logic [15:0]     unit;
    logic [CP_W-1:0] supp;
    logic            big;
    int              pick;
    text_bytes.delete();
    big = order_reg;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(9, 1)) text_bytes.push_back(8'($urandom_range(255)));
    end else begin
      pick = $urandom_range(3);
      if (pick == 1) begin
        append_unit(MARK_NATIVE, big);
      end else if (pick == 2) begin
        // The mark written in the other order reads as a swapped mark.
        append_unit(MARK_NATIVE, !big);
        big = !big;
      end
      repeat ($urandom_range(8, 1)) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          append_unit(random_bmp(), big);
        end else if (pick < 75) begin
          supp = 21'($urandom_range(CP_MAX, PLANE_BASE)) - PLANE_BASE;
          append_unit(SURR_LO_START | {6'd0, supp[19:10]}, big);
          append_unit(SURR_HI_END | {6'd0, supp[9:0]}, big);
        end else if (pick < 82) begin
          append_unit(SURR_HI_END | 16'($urandom_range(10'h3FF)), big);
        end else if (pick < 89) begin
          append_unit(SURR_LO_START | 16'($urandom_range(10'h3FF)), big);
          append_unit(random_bmp(), big);
        end else if (pick < 94) begin
          append_unit(SURR_LO_START | 16'($urandom_range(10'h3FF)), big);
        end else begin
          unit = 16'($urandom_range(16'hFFFF));
          append_unit(unit, big);
        end
      end
      if ($urandom_range(9) == 0)
        text_bytes.push_back(8'($urandom_range(255)));
    end
    for (int i = 0; i < text_bytes.size(); i++)
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  task automatic run_random_texts(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_text();
  endtask

  // Marks, surrogate pairs at both ends of the range, dropped units and
  // odd endings, all under the little endian default.
  task automatic test_marks_and_surrogates();
    // Native mark, highest code point, high surrogate then a plain unit.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hDB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hD8, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b1);
    // Swapped mark turns the text big endian; lowest supplementary point.
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hD8, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hDC, 1'b0);
    send_byte(8'h00, 1'b1);
    // Lone low, two highs in a row, then a mark value that is not first.
    send_byte(8'h00, 1'b0);
    send_byte(8'hDC, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hD8, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hD8, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b1);
    // Extreme units, then a high surrogate and an odd byte left at the end.
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hD8, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // Big endian default: a native mark and a swapped mark back to little.
  task automatic test_big_endian_default();
    write_default_order(1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Random texts under each default order with gaps on both sides.
  task automatic test_random_texts();
    write_default_order(1'b0);
    run_random_texts(400);
    write_default_order(1'b1);
    run_random_texts(400);
  endtask

  // A stretch at full rate with no gaps and no stalls, then one with gaps under the big endian default.
  task automatic test_full_rate();
    write_default_order(1'b0);
    gaps_on = 1'b0;
    run_random_texts(300);
    gaps_on = 1'b1;
    write_default_order(1'b1);
    run_random_texts(300);
  endtask

  // Receiver: stalls at random while gaps are on.
  always @(posedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(99) >= STALL_PCT) : 1'b1;
  end

  // Compare each accepted word with the oldest prediction.
  always @(posedge clk) begin
    logic [CP_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_code_points.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $display("unexpected word: code_point %06h", code_point);
        fail_count++;
      end else begin
        want = pending_code_points.pop_front();
        if (code_point !== want) begin
          if (fail_count < REPORT_LIMIT)
            $display("code_point mismatch: expected %06h, got %06h", want, code_point);
          fail_count++;
        end
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_marks_and_surrogates();
    test_big_endian_default();
    test_random_texts();
    test_full_rate();
    drain();
    repeat (10) @(posedge clk);
    if (pending_code_points.size() != 0) begin
      $display("%0d expected words never arrived", pending_code_points.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
